// File: rtl/core/fcdma_pkg.sv
// Package for the four-channel DMA controller: widths, codes and step tables.
// Used by the interfaces, the core and the top level.
`default_nettype none
package fcdma_pkg;
    localparam int Channels = 4;
    localparam logic [31:0] LowRegionEnd = 32'h0200_0000;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_XFER    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        TM_IMMEDIATE = 2'd0,
        TM_VBLANK    = 2'd1,
        TM_HBLANK    = 2'd2,
        TM_SPECIAL   = 2'd3
    } t_timing;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  channel;
        logic [31:0] src_start;
        logic [31:0] dst_start;
        logic [15:0] unit_count;
        logic [15:0] control;
        logic [31:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] write_addr;
        logic [31:0] write_data;
        logic        write_wide;
        logic [3:0]  irq_raised;
        logic [3:0]  running_mask;
        logic [3:0]  vblank_mask;
        logic [3:0]  hblank_mask;
        logic [31:0] next_read_addr;
        logic        next_read_needed;
        logic        next_wide;
    } t_out_item;

    function automatic logic [3:0] f_src_step(input logic wide, input logic [1:0] sc);
        logic [3:0] r;
        case (sc)
            2'd0: r = wide ? 4'h4 : 4'h2;
            2'd1: r = wide ? 4'hC : 4'hE;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] f_dest_step(input logic wide, input logic [1:0] dc);
        logic [3:0] r;
        case (dc)
            2'd0: r = wide ? 4'h4 : 4'h2;
            2'd1: r = wide ? 4'hC : 4'hE;
            2'd2: r = 4'h0;
            default: r = wide ? 4'h4 : 4'h2;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/fcdma_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on fcdma_pkg.
`default_nettype none
interface fcdma_in_if;
    logic                 valid;
    logic                 ready;
    fcdma_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fcdma_out_if;
    logic                 valid;
    logic                 ready;
    fcdma_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/four_channel_dma_controller.sv
// Top level of the four-channel DMA controller: channel state and result register.
// Depends on fcdma_pkg and the channel interfaces in fcdma_if.
//
// Each transfer item (register write, start trigger, one-unit transfer or no-op)
// is handled by the combinational channel state logic, and its result is held
// in an output register. A new item is taken every cycle while the result
// register is empty or its result is being taken, so the block sustains one
// item per cycle; the only stall comes from the result side.
`default_nettype none
module four_channel_dma_controller (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    fcdma_in_if.sink     i_item,
    fcdma_out_if.source  o_result
);
    import fcdma_pkg::*;

    logic [31:0] r_reload_src  [Channels];
    logic [31:0] r_reload_dest [Channels];
    logic [15:0] r_reload_count[Channels];
    logic [15:0] r_ctrl        [Channels];
    logic [31:0] r_cur_src     [Channels];
    logic [31:0] r_cur_dest    [Channels];
    logic [15:0] r_cur_count   [Channels];
    logic [Channels-1:0] r_started, r_sound;
    logic [3:0]  r_src_step    [Channels];
    logic [3:0]  r_dest_step   [Channels];
    logic [31:0] r_bus_latch   [Channels];

    logic [31:0] n_reload_src  [Channels];
    logic [31:0] n_reload_dest [Channels];
    logic [15:0] n_reload_count[Channels];
    logic [15:0] n_ctrl        [Channels];
    logic [31:0] n_cur_src     [Channels];
    logic [31:0] n_cur_dest    [Channels];
    logic [15:0] n_cur_count   [Channels];
    logic [Channels-1:0] n_started, n_sound;
    logic [3:0]  n_src_step    [Channels];
    logic [3:0]  n_dest_step   [Channels];
    logic [31:0] n_bus_latch   [Channels];

    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        accept;
    t_in_item    it;

    assign i_item.ready     = !r_out_valid || o_result.ready;
    assign accept           = i_item.valid && i_item.ready;
    assign it               = i_item.payload;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    function automatic logic [1:0] f_lowest(input logic [Channels-1:0] m);
        logic [1:0] r;
        r = '0;
        for (int k = Channels - 1; k >= 0; k--) begin
            if (m[k]) begin
                r = 2'(k);
            end
        end
        return r;
    endfunction

    always_comb begin
        logic [Channels-1:0] run_m;
        logic [1:0]  c;
        logic [1:0]  t;
        logic [15:0] ctl;
        logic [15:0] cmask;
        logic [31:0] amask;
        logic [15:0] h;
        logic [15:0] cnt;
        logic        wide;
        logic        fifo_mode;
        n_reload_src   = r_reload_src;
        n_reload_dest  = r_reload_dest;
        n_reload_count = r_reload_count;
        n_ctrl         = r_ctrl;
        n_cur_src      = r_cur_src;
        n_cur_dest     = r_cur_dest;
        n_cur_count    = r_cur_count;
        n_started      = r_started;
        n_sound        = r_sound;
        n_src_step     = r_src_step;
        n_dest_step    = r_dest_step;
        n_bus_latch    = r_bus_latch;
        n_out          = '0;
        c     = it.channel;
        ctl   = it.control;
        h     = '0;
        cnt   = '0;
        wide  = 1'b0;
        amask = '0;
        fifo_mode = 1'b0;
        for (int k = 0; k < Channels; k++) begin
            run_m[k] = r_ctrl[k][15] && r_started[k];
        end
        t = f_lowest(run_m);
        cmask = (c < 2'd3) ? 16'h3FFF : 16'hFFFF;
        case (t_op'(it.op))
            OP_WRITE: begin
                if (32'(c) < Channels) begin
                    n_reload_src[c]   = it.src_start;
                    n_reload_dest[c]  = it.dst_start;
                    n_reload_count[c] = it.unit_count & cmask;
                    n_ctrl[c]         = ctl;
                    if (ctl[15]) begin
                        if (!r_ctrl[c][15]) begin
                            fifo_mode = (t_timing'(ctl[13:12]) == TM_SPECIAL)
                                && (c == 2'd1 || c == 2'd2);
                            wide  = ctl[10] || fifo_mode;
                            amask = wide ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
                            n_cur_src[c]  = it.src_start & amask;
                            n_cur_dest[c] = it.dst_start & amask;
                            n_sound[c]    = fifo_mode;
                            if (fifo_mode) begin
                                n_ctrl[c]      = ctl | 16'h0400;
                                n_cur_count[c] = 16'd4;
                            end else begin
                                n_cur_count[c] = it.unit_count & cmask;
                                if (t_timing'(ctl[13:12]) == TM_IMMEDIATE) begin
                                    n_started[c]   = 1'b1;
                                    n_dest_step[c] = f_dest_step(ctl[10], ctl[6:5]);
                                    n_src_step[c]  = f_src_step(ctl[10], ctl[8:7]);
                                end
                            end
                        end
                    end else begin
                        n_started[c] = 1'b0;
                    end
                end
            end
            OP_TRIGGER: begin
                if (32'(c) < Channels) begin
                    n_started[c]   = 1'b1;
                    n_dest_step[c] = r_sound[c] ? 4'h0
                        : f_dest_step(r_ctrl[c][10], r_ctrl[c][6:5]);
                    n_src_step[c]  = f_src_step(r_ctrl[c][10], r_ctrl[c][8:7]);
                end
            end
            OP_XFER: begin
                if (run_m != '0) begin
                    wide = r_ctrl[t][10];
                    if (!wide) begin
                        if (r_cur_src[t] >= LowRegionEnd) begin
                            h = it.read_data[15:0];
                            n_bus_latch[t] = {h, h};
                        end else begin
                            h = r_cur_dest[t][1] ? r_bus_latch[t][31:16]
                                                 : r_bus_latch[t][15:0];
                        end
                        n_out.write_data = {16'h0, h};
                    end else begin
                        if (r_cur_src[t] >= LowRegionEnd) begin
                            n_bus_latch[t] = it.read_data;
                        end
                        n_out.write_data = n_bus_latch[t];
                    end
                    n_out.write_valid = 1'b1;
                    n_out.write_addr  = r_cur_dest[t];
                    n_out.write_wide  = wide;
                    n_cur_src[t]  = r_cur_src[t] + {{28{r_src_step[t][3]}}, r_src_step[t]};
                    n_cur_dest[t] = r_cur_dest[t]
                        + {{28{r_dest_step[t][3]}}, r_dest_step[t]};
                    cnt = (r_cur_count[t] - 16'd1) & ((t < 2'd3) ? 16'h3FFF : 16'hFFFF);
                    n_cur_count[t] = cnt;
                    if (cnt == '0) begin
                        n_started[t] = 1'b0;
                        if (r_ctrl[t][14]) begin
                            n_out.irq_raised = 4'(1) << t;
                        end
                        if (r_ctrl[t][9]
                            && t_timing'(r_ctrl[t][13:12]) != TM_IMMEDIATE) begin
                            n_cur_count[t] = r_sound[t] ? 16'd4 : r_reload_count[t];
                            if (r_ctrl[t][6:5] == 2'd3 && !r_sound[t]) begin
                                n_cur_dest[t] = r_reload_dest[t]
                                    & (wide ? 32'hFFFF_FFFC : 32'hFFFF_FFFE);
                            end
                        end else if (!r_ctrl[t][9]) begin
                            n_ctrl[t] = r_ctrl[t] & 16'h7FFF;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < Channels; k++) begin
            run_m[k] = n_ctrl[k][15] && n_started[k];
            n_out.vblank_mask[k] = n_ctrl[k][15]
                && (t_timing'(n_ctrl[k][13:12]) == TM_VBLANK);
            n_out.hblank_mask[k] = n_ctrl[k][15]
                && (t_timing'(n_ctrl[k][13:12]) == TM_HBLANK);
        end
        n_out.running_mask = 4'(run_m);
        if (run_m != '0) begin
            t = f_lowest(run_m);
            n_out.next_read_addr   = n_cur_src[t];
            n_out.next_read_needed = n_cur_src[t] >= LowRegionEnd;
            n_out.next_wide        = n_ctrl[t][10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_started   <= '0;
            r_sound     <= '0;
            for (int k = 0; k < Channels; k++) begin
                r_reload_src[k]   <= '0;
                r_reload_dest[k]  <= '0;
                r_reload_count[k] <= '0;
                r_ctrl[k]         <= '0;
                r_cur_src[k]      <= '0;
                r_cur_dest[k]     <= '0;
                r_cur_count[k]    <= '0;
                r_src_step[k]     <= '0;
                r_dest_step[k]    <= '0;
                r_bus_latch[k]    <= '0;
            end
        end else begin
            if (accept) begin
                r_out_valid    <= 1'b1;
                r_reload_src   <= n_reload_src;
                r_reload_dest  <= n_reload_dest;
                r_reload_count <= n_reload_count;
                r_ctrl         <= n_ctrl;
                r_cur_src      <= n_cur_src;
                r_cur_dest     <= n_cur_dest;
                r_cur_count    <= n_cur_count;
                r_started      <= n_started;
                r_sound        <= n_sound;
                r_src_step     <= n_src_step;
                r_dest_step    <= n_dest_step;
                r_bus_latch    <= n_bus_latch;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/fcdma_checker.sv
// Port-level checks for the four-channel DMA controller, bound to the top level.
// Depends on fcdma_pkg and the channel interfaces.
`default_nettype none
module fcdma_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input fcdma_pkg::t_out_item i_out
);
    import fcdma_pkg::*;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted transfer gave no result");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled while the result register could take a transfer");

    a_irq_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0(i_out.irq_raised))
        else $error("more than one interrupt raised");

    a_no_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out.write_valid |-> i_out.write_addr == '0
            && i_out.write_data == '0 && !i_out.write_wide)
        else $error("write fields set without a write");

    a_next_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.running_mask == '0 |-> i_out.next_read_addr == '0
            && !i_out.next_wide)
        else $error("next read reported with no running channel");
endmodule

bind four_channel_dma_controller fcdma_checker u_fcdma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out       (o_result.payload)
);
`default_nettype wire

// File: test/tb_four_channel_dma_controller.sv
// Testbench for the four-channel DMA controller: drives write, trigger and transfer items
// and checks every result against an internal channel model. Depends on fcdma_pkg and fcdma_if.
`timescale 1ns / 1ps
module tb_four_channel_dma_controller;
    import fcdma_pkg::*;

    class dma_scoreboard;
        logic [31:0] rl_src[4], rl_dest[4], c_src[4], c_dest[4], latch[4];
        logic [15:0] rl_cnt[4], ctl[4], c_cnt[4];
        logic        strt[4], snd[4];
        logic [3:0]  s_step[4], d_step[4];
        t_out_item   pending[$];
        int          errors;

        function new();
            errors = 0;
            for (int i = 0; i < 4; i++) begin
                rl_src[i] = '0; rl_dest[i] = '0; c_src[i] = '0; c_dest[i] = '0;
                latch[i] = '0;
                rl_cnt[i] = '0; ctl[i] = '0; c_cnt[i] = '0;
                strt[i] = 1'b0; snd[i] = 1'b0; s_step[i] = '0; d_step[i] = '0;
            end
        endfunction

        function logic [15:0] cmask(int c);
            return (c < 3) ? 16'h3FFF : 16'hFFFF;
        endfunction

        function logic [31:0] amask(int c);
            return ctl[c][10] ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
        endfunction

        function void load_steps(int c);
            logic w;
            logic [1:0] dc, sc;
            w = ctl[c][10]; dc = ctl[c][6:5]; sc = ctl[c][8:7];
            case (sc)
                2'd0: s_step[c] = w ? 4'h4 : 4'h2;
                2'd1: s_step[c] = w ? 4'hC : 4'hE;
                default: s_step[c] = 4'h0;
            endcase
            if (snd[c]) d_step[c] = 4'h0;
            else case (dc)
                2'd1: d_step[c] = w ? 4'hC : 4'hE;
                2'd2: d_step[c] = 4'h0;
                default: d_step[c] = w ? 4'h4 : 4'h2;
            endcase
            strt[c] = 1'b1;
        endfunction

        function logic [3:0] run_mask();
            logic [3:0] m;
            for (int i = 0; i < 4; i++) m[i] = ctl[i][15] & strt[i];
            return m;
        endfunction

        function int lowest(logic [3:0] m);
            for (int i = 0; i < 4; i++) if (m[i]) return i;
            return 0;
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            logic [3:0] m;
            logic [15:0] cw;
            logic [31:0] h;
            int c, t;
            r = '0;
            c = it.channel;
            if (it.op == OP_WRITE) begin
                logic old_en;
                old_en = ctl[c][15];
                rl_src[c] = it.src_start; rl_dest[c] = it.dst_start;
                rl_cnt[c] = it.unit_count & cmask(c);
                ctl[c] = it.control;
                if (it.control[15]) begin
                    if (!old_en) begin
                        c_src[c] = rl_src[c]; c_dest[c] = rl_dest[c];
                        if (it.control[13:12] == TM_SPECIAL && (c == 1 || c == 2)) begin
                            ctl[c][10] = 1'b1; c_cnt[c] = 16'd4;
                            c_src[c] &= 32'hFFFF_FFFC; c_dest[c] &= 32'hFFFF_FFFC;
                            snd[c] = 1'b1;
                        end else begin
                            snd[c] = 1'b0;
                            c_src[c] &= amask(c); c_dest[c] &= amask(c);
                            c_cnt[c] = rl_cnt[c];
                            if (it.control[13:12] == TM_IMMEDIATE) load_steps(c);
                        end
                    end
                end else strt[c] = 1'b0;
            end else if (it.op == OP_TRIGGER) begin
                load_steps(c);
            end else if (it.op == OP_XFER && run_mask() != 0) begin
                t = lowest(run_mask());
                if (!ctl[t][10]) begin
                    if (c_src[t] >= LowRegionEnd) begin
                        h = {16'h0, it.read_data[15:0]};
                        latch[t] = {h[15:0], h[15:0]};
                    end else h = c_dest[t][1] ? {16'h0, latch[t][31:16]}
                                              : {16'h0, latch[t][15:0]};
                    r.write_data = h;
                end else begin
                    if (c_src[t] >= LowRegionEnd) latch[t] = it.read_data;
                    r.write_data = latch[t];
                end
                r.write_valid = 1'b1; r.write_addr = c_dest[t]; r.write_wide = ctl[t][10];
                c_src[t] += {{28{s_step[t][3]}}, s_step[t]};
                c_dest[t] += {{28{d_step[t][3]}}, d_step[t]};
                c_cnt[t] = (c_cnt[t] - 16'd1) & cmask(t);
                if (c_cnt[t] == 0) begin
                    cw = ctl[t];
                    strt[t] = 1'b0;
                    if (cw[14]) r.irq_raised = 4'b1 << t;
                    if (cw[9] && cw[13:12] != TM_IMMEDIATE) begin
                        c_cnt[t] = snd[t] ? 16'd4 : rl_cnt[t];
                        if (cw[6:5] == 2'd3 && !snd[t]) c_dest[t] = rl_dest[t] & amask(t);
                    end else if (!cw[9]) ctl[t][15] = 1'b0;
                end
            end
            m = run_mask();
            r.running_mask = m;
            for (int i = 0; i < 4; i++) begin
                r.vblank_mask[i] = ctl[i][15] && ctl[i][13:12] == TM_VBLANK;
                r.hblank_mask[i] = ctl[i][15] && ctl[i][13:12] == TM_HBLANK;
            end
            if (m != 0) begin
                t = lowest(m);
                r.next_read_addr = c_src[t];
                r.next_read_needed = c_src[t] >= LowRegionEnd;
                r.next_wide = ctl[t][10];
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                $display("%0t: mismatch expected %h actual %h", $time, e, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    fcdma_in_if  item_if();
    fcdma_out_if res_if();
    dma_scoreboard sb;
    int send_idle, recv_stall, quiet_cycles;

    four_channel_dma_controller uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_if.sink), .o_result(res_if.source)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) sb.check_result(res_if.payload);
        res_if.ready <= ($urandom_range(99) >= recv_stall);
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles > 5000) begin
            $display("tb_four_channel_dma_controller: FAIL");
            $finish;
        end
    end

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.payload <= it;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    function automatic t_in_item rand_item(int mode);
        t_in_item it;
        it.op = ($urandom_range(99) < 3) ? OP_NONE : t_op'($urandom_range(2));
        if (mode == 1 && it.op == OP_XFER && $urandom_range(1)) it.op = OP_WRITE;
        it.channel = 2'($urandom_range(3));
        it.src_start = $urandom_range(1) ? $urandom : $urandom_range(32'h0300_0000);
        it.dst_start = $urandom;
        it.unit_count = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5));
        it.control = 16'($urandom);
        if ($urandom_range(1)) it.control[15] = ~it.control[15] | 1'($urandom_range(1));
        it.read_data = $urandom;
        return it;
    endfunction

    task automatic wait_drain();
        item_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic directed();
        t_in_item it;
        it = '0;
        send_item(it);
        it.op = OP_XFER; send_item(it);
        it.op = OP_WRITE; it.channel = 0; it.src_start = 32'hFFFF_FFFF;
        it.dst_start = 32'hFFFF_FFFF; it.unit_count = 0; it.control = 16'h8000;
        it.read_data = 32'hFFFF_FFFF;
        send_item(it);
        it.op = OP_XFER; send_item(it); send_item(it);
        it.op = OP_WRITE; it.channel = 1; it.src_start = 32'h0000_0013;
        it.dst_start = 32'h0400_00A3; it.control = 16'hF2E0; it.unit_count = 16'hFFFF;
        send_item(it);
        it.op = OP_TRIGGER; send_item(it);
        it.op = OP_WRITE; it.channel = 0; it.control = 16'h0000; send_item(it);
        it.op = OP_XFER;
        repeat (5) send_item(it);
        it.op = OP_WRITE; it.channel = 3; it.src_start = 32'h0100_0000;
        it.dst_start = 32'h0000_0002; it.unit_count = 1; it.control = 16'hC3E0;
        it.channel = 1; it.control = 16'h0000; send_item(it);
        it.channel = 3; it.control = 16'hC1E0; send_item(it);
        it.op = OP_TRIGGER; send_item(it);
        it.op = OP_XFER; send_item(it);
        it.op = OP_TRIGGER; send_item(it);
        it.op = OP_XFER; it.read_data = 32'h1234_5678; send_item(it);
        it.op = OP_NONE; send_item(it);
        it.op = OP_TRIGGER; it.channel = 2; send_item(it);
        it.op = OP_WRITE; it.control = 16'h8540; it.unit_count = 2; send_item(it);
        it.op = OP_XFER; send_item(it); send_item(it);
    endtask

    initial begin
        sb = new();
        send_idle = 0; recv_stall = 0; quiet_cycles = 0;
        i_rst_n = 0;
        item_if.valid = 0; item_if.payload = '0; res_if.ready = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        directed();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 53) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 53) : 0;
            for (int n = 0; n < 200; n++) begin
                send_item(rand_item(n % 2));
                if (n == 100) wait_drain();
            end
        end
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_four_channel_dma_controller: PASS");
        else
            $display("tb_four_channel_dma_controller: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/fcdma_pkg.sv
rtl/core/fcdma_if.sv
rtl/core/four_channel_dma_controller.sv
rtl/core/fcdma_checker.sv
test/tb_four_channel_dma_controller.sv
